// ===== hw/rtl/bpa_pkg.sv =====
// Shared types, constants and helpers of the bitmap page allocator.
`default_nettype none
package bpa_pkg;

  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_W     = 5;

  typedef logic [WORD_BITS-1:0] bpa_word_t;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC       = 2'd0,
    OP_FREE_PAGE   = 2'd1,
    OP_FREE_REGION = 2'd2,
    OP_MARK_ALL    = 2'd3
  } bpa_op_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, clear result, rewind indexes
    logic fill;      // write all ones at the sweep index, step it
    logic cnt_clr;   // zero the net page counter
    logic scan;      // stream bitmap words into the free-bit check
    logic commit;    // set the found bit, bump counter, latch address
    logic calc_n;    // clamp page count to the end of the bitmap
    logic calc_end;  // last page of the span, counter update
    logic rmw_rd;    // read the current span word
    logic rmw_wr;    // write it back with the span bits cleared
    logic out_load;  // move the result into the response register
  } bpa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;        // checked word holds a free page
    logic exhausted;  // last word checked, nothing free
    logic n_zero;     // span is empty
    logic last_word;  // current word is the last of the span
    logic fill_last;  // sweep index at the last word
  } bpa_sts_t;

  // Index of the lowest clear bit.
  function automatic logic [BIT_W-1:0] first_zero(input bpa_word_t w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bpa_if.sv =====
// Request and response channel interfaces of the bitmap page allocator.
`default_nettype none
interface bpa_req_if;
  logic                           valid;
  logic                           ready;
  logic [bpa_pkg::OP_W-1:0]       operation;
  logic [bpa_pkg::ADDR_W-1:0]     address;
  logic [bpa_pkg::ADDR_W-1:0]     length;

  modport source (output valid, operation, address, length, input ready);
  modport sink   (input valid, operation, address, length, output ready);
endinterface

interface bpa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bpa_pkg::ADDR_W-1:0]     page_address;
  logic                           found;
  logic signed [bpa_pkg::CNT_W-1:0] used_pages;

  modport source (output valid, page_address, found, used_pages, input ready);
  modport sink   (input valid, page_address, found, used_pages, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bpa_datapath.sv =====
// Datapath: bitmap memory, scan and span logic, counter and result registers.
`default_nettype none
module bpa_datapath #(
  parameter int unsigned NUM_PAGES  = 32768,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  bpa_pkg::bpa_cmd_t             cmd_i,
  input  bpa_pkg::bpa_op_e              op_i,
  input  wire [bpa_pkg::ADDR_W-1:0]     address_i,
  input  wire [bpa_pkg::ADDR_W-1:0]     length_i,
  output bpa_pkg::bpa_sts_t             sts_o,
  output logic [bpa_pkg::ADDR_W-1:0]    page_address_o,
  output logic                          found_o,
  output logic [bpa_pkg::CNT_W-1:0]     used_pages_o
);

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned NWORDS     = (NUM_PAGES + bpa_pkg::WORD_BITS - 1) / bpa_pkg::WORD_BITS;
  localparam int unsigned WIW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned PW         = WIW + bpa_pkg::BIT_W;
  localparam int unsigned EW         = PW + 1;
  localparam int unsigned PN_W       = bpa_pkg::ADDR_W - PAGE_SHIFT;
  localparam int unsigned WB         = bpa_pkg::WORD_BITS;
  localparam int unsigned BW         = bpa_pkg::BIT_W;
  localparam logic [WIW-1:0]  LAST_WORD    = WIW'(NWORDS - 1);
  localparam logic [PN_W-1:0] NUM_PAGES_PN = PN_W'(NUM_PAGES);
  localparam logic [EW-1:0]   NUM_PAGES_E  = EW'(NUM_PAGES);

  // bitmap storage
  logic [WB-1:0] mem_q [NWORDS];
  logic [WB-1:0] rd_data_q;
  logic          mem_we, mem_re;
  logic [WIW-1:0] mem_wa, mem_ra;
  logic [WB-1:0] mem_wd;

  // request state
  logic [PW-1:0] start_q, end_q;
  logic [EW-1:0] count_q, n_q;
  logic [WIW-1:0] cur_w_q;

  // scan state
  logic [WIW-1:0] rd_idx_q, chk_idx_q;
  logic           rd_end_q, pend_q;

  logic [bpa_pkg::CNT_W-1:0]  cnt_q;
  logic [bpa_pkg::ADDR_W-1:0] res_addr_q, out_addr_q;
  logic                       res_found_q, out_found_q;
  logic [bpa_pkg::CNT_W-1:0]  out_used_q;

  logic [PN_W-1:0] pn_addr, pn_len;
  logic            in_range;
  logic [EW-1:0]   count_d, room, n_d;
  logic            issue, hit;
  logic [BW-1:0]   fz, lo, hi;
  logic [WB-1:0]   mask;
  logic [WIW-1:0]  start_w, end_w;

  assign pn_addr  = address_i[bpa_pkg::ADDR_W-1:PAGE_SHIFT];
  assign pn_len   = length_i[bpa_pkg::ADDR_W-1:PAGE_SHIFT];
  assign in_range = pn_addr < NUM_PAGES_PN;

  always_comb begin
    if (!in_range) begin
      count_d = '0;
    end else if (op_i == bpa_pkg::OP_FREE_PAGE) begin
      count_d = EW'(1);
    end else if (pn_len > NUM_PAGES_PN) begin
      count_d = NUM_PAGES_E;
    end else begin
      count_d = EW'(pn_len);
    end
  end

  assign room = NUM_PAGES_E - EW'(start_q);
  assign n_d  = (count_q < room) ? count_q : room;

  assign issue   = !rd_end_q;
  assign hit     = pend_q && (rd_data_q != '1);
  assign fz      = bpa_pkg::first_zero(rd_data_q);
  assign start_w = start_q[PW-1:BW];
  assign end_w   = end_q[PW-1:BW];

  // span bits inside the current word
  assign lo   = (cur_w_q == start_w) ? start_q[BW-1:0] : '0;
  assign hi   = (cur_w_q == end_w) ? end_q[BW-1:0] : '1;
  assign mask = ({WB{1'b1}} << lo) & ({WB{1'b1}} >> (BW'(WB - 1) - hi));

  assign sts_o.hit       = hit;
  assign sts_o.exhausted = pend_q && !hit && (chk_idx_q == LAST_WORD);
  assign sts_o.n_zero    = (n_q == '0);
  assign sts_o.last_word = (cur_w_q == end_w);
  assign sts_o.fill_last = (cur_w_q == LAST_WORD);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_w_q;
    mem_wd = '1;
    mem_re = 1'b0;
    mem_ra = cur_w_q;
    if (cmd_i.fill) begin
      mem_we = 1'b1;
    end else if (cmd_i.commit) begin
      mem_we = 1'b1;
      mem_wa = chk_idx_q;
      mem_wd = rd_data_q | (WB'(1) << fz);
    end else if (cmd_i.rmw_wr) begin
      mem_we = 1'b1;
      mem_wd = rd_data_q & ~mask;
    end
    if (cmd_i.scan && issue) begin
      mem_re = 1'b1;
      mem_ra = rd_idx_q;
    end else if (cmd_i.rmw_rd) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (mem_re) rd_data_q <= mem_q[mem_ra];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_w_q   <= '0;
      rd_idx_q  <= '0;
      chk_idx_q <= '0;
      rd_end_q  <= 1'b0;
      pend_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        cur_w_q  <= '0;
        rd_idx_q <= '0;
        rd_end_q <= 1'b0;
        pend_q   <= 1'b0;
      end
      if (cmd_i.scan) begin
        pend_q <= issue;
        if (issue) begin
          chk_idx_q <= rd_idx_q;
          if (rd_idx_q == LAST_WORD) rd_end_q <= 1'b1;
          else                       rd_idx_q <= rd_idx_q + WIW'(1);
        end
      end
      if (cmd_i.fill || cmd_i.rmw_wr) cur_w_q <= cur_w_q + WIW'(1);
      if (cmd_i.calc_end) begin
        cur_w_q <= start_w;
        cnt_q   <= cnt_q - bpa_pkg::CNT_W'(n_q);
      end
      if (cmd_i.commit)  cnt_q <= cnt_q + bpa_pkg::CNT_W'(1);
      if (cmd_i.cnt_clr) cnt_q <= '0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      start_q     <= PW'(pn_addr);
      count_q     <= count_d;
      res_addr_q  <= '0;
      res_found_q <= 1'b0;
    end
    if (cmd_i.calc_n)   n_q   <= n_d;
    if (cmd_i.calc_end) end_q <= PW'(EW'(start_q) + n_q - EW'(1));
    if (cmd_i.commit) begin
      res_addr_q  <= bpa_pkg::ADDR_W'({chk_idx_q, fz}) << PAGE_SHIFT;
      res_found_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      out_addr_q  <= res_addr_q;
      out_found_q <= res_found_q;
      out_used_q  <= cnt_q;
    end
  end

  assign page_address_o = out_addr_q;
  assign found_o        = out_found_q;
  assign used_pages_o   = out_used_q;

endmodule
`default_nettype wire

// ===== hw/rtl/bpa_ctrl.sv =====
// Controller: sequences clearing, scan, span update and response hand-off.
`default_nettype none
module bpa_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    req_valid_i,
  input  bpa_pkg::bpa_op_e       req_op_i,
  output logic                   req_ready_o,
  input  wire                    rsp_ready_i,
  output logic                   rsp_valid_o,
  input  bpa_pkg::bpa_sts_t      sts_i,
  output bpa_pkg::bpa_cmd_t      cmd_o
);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_PREP_N   = 4'd3;
  localparam logic [3:0] S_PREP_END = 4'd4;
  localparam logic [3:0] S_RD       = 4'd5;
  localparam logic [3:0] S_WR       = 4'd6;
  localparam logic [3:0] S_MARK     = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0] state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    unique case (state_q)
      S_INIT: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (req_op_i) inside
            bpa_pkg::OP_ALLOC:                              state_d = S_SCAN;
            bpa_pkg::OP_FREE_PAGE, bpa_pkg::OP_FREE_REGION: state_d = S_PREP_N;
            default:                                        state_d = S_MARK;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit) begin
          cmd_o.commit = 1'b1;
          state_d      = S_DONE;
        end else if (sts_i.exhausted) begin
          state_d = S_DONE;
        end
      end
      S_PREP_N: begin
        cmd_o.calc_n = 1'b1;
        state_d      = S_PREP_END;
      end
      S_PREP_END: begin
        cmd_o.calc_end = 1'b1;
        state_d        = sts_i.n_zero ? S_DONE : S_RD;
      end
      S_RD: begin
        cmd_o.rmw_rd = 1'b1;
        state_d      = S_WR;
      end
      S_WR: begin
        cmd_o.rmw_wr = 1'b1;
        state_d      = sts_i.last_word ? S_DONE : S_RD;
      end
      S_MARK: begin
        cmd_o.fill    = 1'b1;
        cmd_o.cnt_clr = 1'b1;
        if (sts_i.fill_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          rsp_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule
`default_nettype wire

// ===== hw/rtl/bitmap_page_allocator_unit.sv =====
// Top level of the bitmap page allocator: controller plus datapath.
//
// One used bit per page is kept in a memory of 32-bit words, with a net
// page counter beside it. Requests arrive on req_i (valid/ready); each one
// gives exactly one response on rsp_o (valid/ready) carrying page_address,
// found and used_pages after the request.
// Requests are handled one at a time. Work from accept to response valid:
//   allocate       : bitmap words are scanned up to the first one with
//                    a free bit (all NUM_PAGES/32 words when memory is full);
//                    the single read port of the bitmap memory streams one
//                    word per cycle.
//   free page      : one read-modify-write of the word, none when the page
//                    is past the end of the bitmap.
//   free region    : one read-modify-write per bitmap word touched by the span.
//   mark all used  : all words set to ones, one word written per cycle.
// Reset: the bitmap is swept to all ones, one word per cycle, while
// req_i.ready stays low. The counter resets to zero.
// The response sits in an output register, so the next request is taken
// while rsp_o is stalled; a finished result then waits until the register
// frees before it is loaded.
`default_nettype none
module bitmap_page_allocator_unit #(
  parameter int unsigned NUM_PAGES  = 32768,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  bpa_req_if.sink     req_i,
  bpa_rsp_if.source   rsp_o
);

  bpa_pkg::bpa_cmd_t             cmd;
  bpa_pkg::bpa_sts_t             sts;
  bpa_pkg::bpa_op_e              op;
  logic                          req_ready;
  logic                          rsp_valid;
  logic [bpa_pkg::ADDR_W-1:0]    page_address;
  logic                          found;
  logic [bpa_pkg::CNT_W-1:0]     used_pages;

  assign op = bpa_pkg::bpa_op_e'(req_i.operation);

  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (op),
    .req_ready_o (req_ready),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bpa_datapath #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (op),
    .address_i      (req_i.address),
    .length_i       (req_i.length),
    .sts_o          (sts),
    .page_address_o (page_address),
    .found_o        (found),
    .used_pages_o   (used_pages)
  );

  assign req_i.ready        = req_ready;
  assign rsp_o.valid        = rsp_valid;
  assign rsp_o.page_address = page_address;
  assign rsp_o.found        = found;
  assign rsp_o.used_pages   = $signed(used_pages);

endmodule
`default_nettype wire

// ===== hw/rtl/bpa_checker.sv =====
// Port-level checker of the bitmap page allocator and its bind.
`default_nettype none
module bpa_checker #(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         req_valid_i,
  input wire                         req_ready_i,
  input wire                         rsp_valid_i,
  input wire                         rsp_ready_i,
  input wire [bpa_pkg::ADDR_W-1:0]   page_address_i,
  input wire                         found_i,
  input wire [bpa_pkg::CNT_W-1:0]    used_pages_i
);

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);

  // one request in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request accepted while previous one in flight");

  a_addr_zero_if_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !found_i) |-> (page_address_i == '0))
    else $error("nonzero page address without found");

  a_addr_page_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (page_address_i[PAGE_SHIFT-1:0] == '0))
    else $error("page address not page aligned");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(page_address_i) && $stable(found_i) && $stable(used_pages_i)))
    else $error("stalled response changed");

endmodule

bind bitmap_page_allocator_unit bpa_checker #(
  .PAGE_BYTES (PAGE_BYTES)
) u_bpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .page_address_i (rsp_o.page_address),
  .found_i        (rsp_o.found),
  .used_pages_i   (rsp_o.used_pages)
);
`default_nettype wire
